@@ rtl/cae_pkg.sv @@
// ----------------------------------------------------------------------------
// cae_pkg
// Types, opcode codes and flag positions shared by the register execute block.
// ----------------------------------------------------------------------------
package cae_pkg;

  typedef struct packed {
    logic [7:0] action;
    logic [7:0] operand;
  } in_t;

  typedef struct packed {
    logic [7:0] acc_out;
    logic [7:0] x_out;
    logic [7:0] y_out;
    logic [7:0] flags_out;
    logic       undefined_op;
  } out_t;

  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] flags;
  } arch_t;

  typedef enum logic [3:0] {
    K_NONE = 4'd0,
    K_ADC  = 4'd1,
    K_SBC  = 4'd2,
    K_AND  = 4'd3,
    K_ORA  = 4'd4,
    K_EOR  = 4'd5,
    K_BIT  = 4'd6,
    K_CMP  = 4'd7,
    K_CPX  = 4'd8,
    K_CPY  = 4'd9,
    K_LDA  = 4'd10,
    K_LDX  = 4'd11,
    K_LDY  = 4'd12
  } alu_kind_e;

  localparam int unsigned FlagN = 7;
  localparam int unsigned FlagV = 6;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagC = 0;

  localparam logic [7:0] OP_ADC_IMM = 8'h69;
  localparam logic [7:0] OP_ADC_ABS = 8'h6D;
  localparam logic [7:0] OP_ADC_ZP  = 8'h65;
  localparam logic [7:0] OP_ADC_IZX = 8'h61;
  localparam logic [7:0] OP_SBC_IMM = 8'hE9;
  localparam logic [7:0] OP_SBC_ABS = 8'hED;
  localparam logic [7:0] OP_SBC_ZP  = 8'hE5;
  localparam logic [7:0] OP_SBC_IZX = 8'hE1;
  localparam logic [7:0] OP_AND_IMM = 8'h29;
  localparam logic [7:0] OP_AND_ABS = 8'h2D;
  localparam logic [7:0] OP_AND_ZP  = 8'h25;
  localparam logic [7:0] OP_AND_IZX = 8'h21;
  localparam logic [7:0] OP_ORA_IMM = 8'h09;
  localparam logic [7:0] OP_ORA_ABS = 8'h0D;
  localparam logic [7:0] OP_ORA_ZP  = 8'h05;
  localparam logic [7:0] OP_ORA_IZX = 8'h01;
  localparam logic [7:0] OP_EOR_IMM = 8'h49;
  localparam logic [7:0] OP_EOR_ABS = 8'h4D;
  localparam logic [7:0] OP_EOR_ZP  = 8'h45;
  localparam logic [7:0] OP_EOR_IZX = 8'h41;
  localparam logic [7:0] OP_BIT_ABS = 8'h2C;
  localparam logic [7:0] OP_BIT_ZP  = 8'h24;
  localparam logic [7:0] OP_CMP_IMM = 8'hC9;
  localparam logic [7:0] OP_CMP_ABS = 8'hCD;
  localparam logic [7:0] OP_CMP_ZP  = 8'hC5;
  localparam logic [7:0] OP_CMP_IZX = 8'hC1;
  localparam logic [7:0] OP_CPX_IMM = 8'hE0;
  localparam logic [7:0] OP_CPX_ABS = 8'hEC;
  localparam logic [7:0] OP_CPX_ZP  = 8'hE4;
  localparam logic [7:0] OP_CPY_IMM = 8'hC0;
  localparam logic [7:0] OP_CPY_ABS = 8'hCC;
  localparam logic [7:0] OP_CPY_ZP  = 8'hC4;
  localparam logic [7:0] OP_LDA_IMM = 8'hA9;
  localparam logic [7:0] OP_LDA_ABS = 8'hAD;
  localparam logic [7:0] OP_LDA_ZP  = 8'hA5;
  localparam logic [7:0] OP_LDA_IZX = 8'hA1;
  localparam logic [7:0] OP_LDX_IMM = 8'hA2;
  localparam logic [7:0] OP_LDX_ABS = 8'hAE;
  localparam logic [7:0] OP_LDX_ZP  = 8'hA6;
  localparam logic [7:0] OP_LDY_IMM = 8'hA0;
  localparam logic [7:0] OP_LDY_ABS = 8'hAC;
  localparam logic [7:0] OP_LDY_ZP  = 8'hA4;

endpackage

@@ rtl/cae_decode.sv @@
// ----------------------------------------------------------------------------
// cae_decode
// Map an opcode byte to its ALU operation class.
// ----------------------------------------------------------------------------
module cae_decode (
  input  logic [7:0]         action_i,
  output cae_pkg::alu_kind_e kind_o
);
  import cae_pkg::*;

  always_comb begin
    unique case (action_i)
      OP_ADC_IMM, OP_ADC_ABS, OP_ADC_ZP, OP_ADC_IZX: kind_o = K_ADC;
      OP_SBC_IMM, OP_SBC_ABS, OP_SBC_ZP, OP_SBC_IZX: kind_o = K_SBC;
      OP_AND_IMM, OP_AND_ABS, OP_AND_ZP, OP_AND_IZX: kind_o = K_AND;
      OP_ORA_IMM, OP_ORA_ABS, OP_ORA_ZP, OP_ORA_IZX: kind_o = K_ORA;
      OP_EOR_IMM, OP_EOR_ABS, OP_EOR_ZP, OP_EOR_IZX: kind_o = K_EOR;
      OP_BIT_ABS, OP_BIT_ZP:                         kind_o = K_BIT;
      OP_CMP_IMM, OP_CMP_ABS, OP_CMP_ZP, OP_CMP_IZX: kind_o = K_CMP;
      OP_CPX_IMM, OP_CPX_ABS, OP_CPX_ZP:             kind_o = K_CPX;
      OP_CPY_IMM, OP_CPY_ABS, OP_CPY_ZP:             kind_o = K_CPY;
      OP_LDA_IMM, OP_LDA_ABS, OP_LDA_ZP, OP_LDA_IZX: kind_o = K_LDA;
      OP_LDX_IMM, OP_LDX_ABS, OP_LDX_ZP:             kind_o = K_LDX;
      OP_LDY_IMM, OP_LDY_ABS, OP_LDY_ZP:             kind_o = K_LDY;
      default:                                       kind_o = K_NONE;
    endcase
  end

endmodule

@@ rtl/cae_alu.sv @@
// ----------------------------------------------------------------------------
// cae_alu
// Compute the next register state for one operation class and operand.
// ----------------------------------------------------------------------------
module cae_alu (
  input  cae_pkg::alu_kind_e kind_i,
  input  logic [7:0]         operand_i,
  input  cae_pkg::arch_t     state_i,
  output cae_pkg::arch_t     state_o
);
  import cae_pkg::*;

  logic [7:0] add_m;
  logic [8:0] sum;
  logic [7:0] cmp_reg;
  logic [8:0] diff;
  logic [7:0] logic_res;
  logic       add_v;

  assign add_m   = (kind_i == K_SBC) ? ~operand_i : operand_i;
  assign sum     = {1'b0, state_i.acc} + {1'b0, add_m} + {8'd0, state_i.flags[FlagC]};
  assign add_v   = ~(state_i.acc[7] ^ add_m[7]) & (state_i.acc[7] ^ sum[7]);
  assign cmp_reg = (kind_i == K_CPX) ? state_i.x :
                   (kind_i == K_CPY) ? state_i.y : state_i.acc;
  assign diff    = {1'b0, cmp_reg} - {1'b0, operand_i};

  always_comb begin
    unique case (kind_i)
      K_AND:   logic_res = state_i.acc & operand_i;
      K_ORA:   logic_res = state_i.acc | operand_i;
      K_EOR:   logic_res = state_i.acc ^ operand_i;
      default: logic_res = operand_i;
    endcase
  end

  always_comb begin
    state_o = state_i;
    unique case (kind_i)
      K_ADC, K_SBC: begin
        state_o.acc          = sum[7:0];
        state_o.flags[FlagC] = sum[8];
        state_o.flags[FlagV] = add_v;
        state_o.flags[FlagN] = sum[7];
        state_o.flags[FlagZ] = (sum[7:0] == 8'd0);
      end
      K_AND, K_ORA, K_EOR, K_LDA: begin
        state_o.acc          = logic_res;
        state_o.flags[FlagN] = logic_res[7];
        state_o.flags[FlagZ] = (logic_res == 8'd0);
      end
      K_LDX: begin
        state_o.x            = operand_i;
        state_o.flags[FlagN] = operand_i[7];
        state_o.flags[FlagZ] = (operand_i == 8'd0);
      end
      K_LDY: begin
        state_o.y            = operand_i;
        state_o.flags[FlagN] = operand_i[7];
        state_o.flags[FlagZ] = (operand_i == 8'd0);
      end
      K_BIT: begin
        state_o.flags[FlagN] = operand_i[7];
        state_o.flags[FlagV] = operand_i[6];
        state_o.flags[FlagZ] = ((state_i.acc & operand_i) == 8'd0);
      end
      K_CMP, K_CPX, K_CPY: begin
        state_o.flags[FlagC] = ~diff[8];
        state_o.flags[FlagN] = diff[7];
        state_o.flags[FlagZ] = (diff[7:0] == 8'd0);
      end
      K_NONE: begin
        state_o = state_i;
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

@@ rtl/cpu_alu_register_execute.sv @@
// Path: a transaction is accepted into the input register, passes decode and the ALU,
// and its result is captured in the output register.
// Throughput: one transaction per cycle while out_ready_i does not stall the output;
// the accumulator and flag feedback runs through the combinational ALU.
// Reset: rst_ni clears A, X, Y, status and both valid bits to zero.
// ----------------------------------------------------------------------------
// cpu_alu_register_execute
// Binary-mode accumulator/index execute stage: input register, decode and ALU,
// architectural registers and output register with valid/ready on both sides.
// ----------------------------------------------------------------------------
module cpu_alu_register_execute (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cae_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cae_pkg::out_t out_data_o
);
  import cae_pkg::*;

  in_t       in_q;
  logic      in_valid_q;
  arch_t     state_q;
  arch_t     state_d;
  out_t      out_q;
  logic      out_valid_q;
  alu_kind_e kind;
  logic      advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  cae_decode u_decode (
    .action_i (in_q.action),
    .kind_o   (kind)
  );

  cae_alu u_alu (
    .kind_i    (kind),
    .operand_i (in_q.operand),
    .state_i   (state_q),
    .state_o   (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.acc_out      <= state_d.acc;
      out_q.x_out        <= state_d.x;
      out_q.y_out        <= state_d.y;
      out_q.flags_out    <= state_d.flags;
      out_q.undefined_op <= (kind == K_NONE);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_undef_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (kind == K_NONE) |=> state_q == $past(state_q))
    else $error("undefined opcode changed register state");

  a_out_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_q.acc_out == state_q.acc) && (out_q.x_out == state_q.x)
      && (out_q.y_out == state_q.y) && (out_q.flags_out == state_q.flags))
    else $error("output register disagrees with architectural state");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("executed transaction did not reach the output register");
`endif

endmodule
